// ===== rtl/core/ntps_pkg.sv =====
// Shared types and constants for the nearest tagged provider search block.
// Depends on nothing; every module of the block imports it.
package ntps_pkg;

    localparam int COORD_W   = 8;
    localparam int LOC_W     = 16;
    localparam int TASK_W    = 16;
    localparam int IN_TAG_W  = 32;
    localparam int DIST_W    = 9;
    localparam int IN_IDX_W  = 5;
    localparam int CMD_IDX_W = 8;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_LAST,
        BK_RESULT
    } bk_state_t;

    typedef struct packed {
        logic                operation;
        logic [IN_IDX_W-1:0] entry_index;
        logic                entry_valid;
        logic [IN_TAG_W-1:0] entry_tag;
        logic [LOC_W-1:0]    entry_location;
        logic [TASK_W-1:0]   entry_task_id;
        logic [LOC_W-1:0]    query_location;
        logic [IN_TAG_W-1:0] query_tag;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [TASK_W-1:0] provider_task_id;
        logic [DIST_W-1:0] provider_distance;
    } out_item_t;

    // One classified command between front and back. Tag and location hold
    // the entry fields for a write and the query fields for a query.
    typedef struct packed {
        op_t                  kind;
        logic [CMD_IDX_W-1:0] index;
        logic                 valid;
        logic [IN_TAG_W-1:0]  tag;
        logic [LOC_W-1:0]     location;
        logic [TASK_W-1:0]    task_id;
    } cmd_t;

endpackage

// ===== rtl/core/nearest_tagged_provider_search_unit.sv =====
// Top level of the nearest tagged provider search block.
// Depends on ntps_pkg, ntps_front, ntps_queue and ntps_back.
//
// Usage:
//   s_valid/s_ready/s_payload carry commands. A write (operation 0) sets or
//   frees one table slot and gives no result; writes to a slot beyond the
//   table are accepted and dropped. A query (operation 1) gives a location
//   and a required tag mask and yields one transfer on m_valid/m_ready/
//   m_payload: the valid slot holding all required bits with the least
//   Manhattan distance, lowest index on a tie, or all zeros if none matches.
//
// Flow:
//   The front end feeds a two-entry command queue, so s_ready stays high
//   while the queue has room. The back end executes writes only in BK_IDLE.
//   For a query, the scan reads one slot per cycle from the single table
//   read port, then BK_LAST finishes the last compare and BK_RESULT loads
//   the result register. The next query leaves the queue only once the
//   result is taken.
//
// Reset clears all valid marks, the queue and the result valid flag. While
// the receiver stalls, hold the result; writes ahead of the next query keep
// draining from the queue, and that query waits until the pending result is taken.
module nearest_tagged_provider_search_unit #(
    parameter int TABLE_ENTRIES = 32,
    parameter int TAG_BITS      = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ntps_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ntps_pkg::out_item_t m_payload
);
    import ntps_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_data;
    cmd_t q_head;

    // Classify each accepted transfer and drop out-of-range writes.
    ntps_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    // Decouple the input side from the table scan.
    ntps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_data),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Execute writes and scan the table for queries.
    ntps_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .TAG_BITS     (TAG_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

// ===== rtl/core/ntps_front.sv =====
// Front end: accepts input transfers, drops out-of-range writes and packs
// the rest into commands. Depends on ntps_pkg.
module ntps_front #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  ntps_pkg::in_item_t s_payload,
    input  logic              q_full,
    output logic              q_push,
    output ntps_pkg::cmd_t    q_data
);
    import ntps_pkg::*;

    localparam logic [CMD_IDX_W:0] ENTRIES_WIDE = (CMD_IDX_W + 1)'(TABLE_ENTRIES);

    logic [CMD_IDX_W:0] index_wide;
    logic               is_query;
    logic               in_range;

    assign index_wide = {{(CMD_IDX_W + 1 - IN_IDX_W){1'b0}}, s_payload.entry_index};
    assign is_query   = (s_payload.operation == OP_QUERY);
    assign in_range   = (index_wide < ENTRIES_WIDE);

    assign s_ready = !q_full;
    // Drop a write to a slot beyond the table: accept it, queue nothing.
    assign q_push  = s_valid && !q_full && (is_query || in_range);

    always_comb begin
        q_data.kind    = op_t'(s_payload.operation);
        q_data.index   = index_wide[CMD_IDX_W-1:0];
        q_data.valid   = s_payload.entry_valid;
        q_data.task_id = s_payload.entry_task_id;
        if (is_query) begin
            q_data.tag      = s_payload.query_tag;
            q_data.location = s_payload.query_location;
        end else begin
            q_data.tag      = s_payload.entry_tag;
            q_data.location = s_payload.entry_location;
        end
    end

endmodule

// ===== rtl/core/ntps_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on ntps_pkg for the command type.
module ntps_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ntps_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ntps_pkg::cmd_t head
);
    import ntps_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ntps_back.sv =====
// Back end: holds the provider table, executes writes and scans the table
// for queries, one slot per cycle. Depends on ntps_pkg.
module ntps_back #(
    parameter int TABLE_ENTRIES = 32,
    parameter int TAG_BITS      = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  ntps_pkg::cmd_t      q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ntps_pkg::out_item_t m_payload
);
    import ntps_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TAG_W = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LOC_W-1:0]  location;
        logic [TASK_W-1:0] task_id;
    } slot_t;

    slot_t                    mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] slot_valid_reg;

    bk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               rd_pend_reg;
    logic               rd_vld_reg;
    slot_t              rd_data_reg;
    logic [LOC_W-1:0]   qloc_reg;
    logic [TAG_W-1:0]   qtag_reg;
    logic               hit_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [TASK_W-1:0]  best_id_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               head_write;
    logic               head_query;
    logic               start_scan;
    logic               do_write;
    logic [IDX_W-1:0]   wr_idx;
    logic [COORD_W-1:0] px, py, qx, qy, dx, dy;
    logic [DIST_W-1:0]  slot_dist;
    logic               tag_ok;
    logic               take;

    assign head_write = !q_empty && (q_head.kind == OP_WRITE);
    assign head_query = !q_empty && (q_head.kind == OP_QUERY);
    assign wr_idx     = q_head.index[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (head_query && !out_valid_reg) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = BK_LAST;
                end
            end
            BK_LAST:   state_next = BK_RESULT;
            BK_RESULT: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        do_write   = 1'b0;
        start_scan = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                do_write   = head_write;
                start_scan = head_query && !out_valid_reg;
            end
            default: begin
                do_write   = 1'b0;
                start_scan = 1'b0;
            end
        endcase
    end

    assign q_pop = do_write || start_scan;

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_idx] <= '{tag:      q_head.tag[TAG_W-1:0],
                             location: q_head.location,
                             task_id:  q_head.task_id};
        end
        rd_data_reg <= mem[scan_idx_reg];
        rd_vld_reg  <= slot_valid_reg[scan_idx_reg];
    end

    // Distance and tag test on the slot read in the previous cycle.
    always_comb begin
        px        = rd_data_reg.location[LOC_W-1:COORD_W];
        py        = rd_data_reg.location[COORD_W-1:0];
        qx        = qloc_reg[LOC_W-1:COORD_W];
        qy        = qloc_reg[COORD_W-1:0];
        dx        = (px > qx) ? (px - qx) : (qx - px);
        dy        = (py > qy) ? (py - qy) : (qy - py);
        slot_dist = {1'b0, dx} + {1'b0, dy};
        tag_ok    = ((rd_data_reg.tag & qtag_reg) == qtag_reg);
        // Strict compare keeps the lowest index on a tie.
        take      = rd_pend_reg && rd_vld_reg && tag_ok
                    && (!hit_reg || slot_dist < best_dist_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            slot_valid_reg <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == BK_SCAN);
            if (do_write) begin
                slot_valid_reg[wr_idx] <= q_head.valid;
            end
            if (state_reg == BK_RESULT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_scan) begin
            scan_idx_reg  <= '0;
            qloc_reg      <= q_head.location;
            qtag_reg      <= q_head.tag[TAG_W-1:0];
            hit_reg       <= 1'b0;
            best_dist_reg <= '0;
            best_id_reg   <= '0;
        end else begin
            if (state_reg == BK_SCAN && scan_idx_reg != LAST_IDX) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (take) begin
                hit_reg       <= 1'b1;
                best_dist_reg <= slot_dist;
                best_id_reg   <= rd_data_reg.task_id;
            end
        end
        if (state_reg == BK_RESULT) begin
            out_reg.found             <= hit_reg;
            out_reg.provider_task_id  <= best_id_reg;
            out_reg.provider_distance <= best_dist_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule
